// File: design/cdss_pkg.sv
// cdss_pkg: types, constants and constant tables shared by the date-to-serial block
// no dependencies; imported by cdss_date_days, cdss_day_frac, the top level and the testbench
`timescale 1ns / 1ps

package cdss_pkg;

    // input item: civil date and time of day
    typedef struct packed {
        logic signed [15:0] year_value;
        logic [3:0]         month_value;
        logic [4:0]         day_value;
        logic [4:0]         hour_value;
        logic [5:0]         minute_value;
        logic [5:0]         second_value;
        logic [9:0]         milli_value;
    } cdss_in_t;

    // result item: serial day and 0.32 fraction of day
    typedef struct packed {
        logic signed [24:0] serial_days;
        logic [31:0]        day_fraction;
    } cdss_out_t;

    // time-of-day path status toward the top level
    typedef struct packed {
        logic        carry;
        logic [31:0] fraction;
    } cdss_frac_t;

    // one term of the fraction sum: quotient and remainder of field * weight * 2^22 / 84375
    typedef struct packed {
        logic [32:0] quo;
        logic [16:0] rem;
    } frac_term_t;

    typedef frac_term_t [63:0] frac_tab_t;
    typedef logic [15:0][8:0]  doy_tab_t;

    // 2^32 / 86400000 reduces to 2^22 / 84375
    localparam longint unsigned MS_DAY_DEN = 64'd84375;
    localparam int              FRAC_SHIFT = 22;

    // year bias keeps the march-based year non-negative (multiple of 400)
    localparam logic [16:0] YEAR_BIAS     = 17'd32800;
    localparam logic [24:0] DAYS_PER_YEAR = 25'd365;

    // floor(n / 25) = (n * 41944) >> 20 for n below 43690
    localparam logic [15:0] DIV25_MUL   = 16'd41944;
    localparam int          DIV25_SHIFT = 20;

    // folds year bias, civil shift, day-1 and the 1899-12-30 epoch into one constant
    localparam logic [24:0] SERIAL_BIAS = 25'(-32'sd12673854);

    function automatic frac_tab_t make_frac_tab(input longint unsigned weight_ms);
        frac_tab_t       tab;
        longint unsigned prod;
        for (int i = 0; i < 64; i++)
        begin
            prod = longint'(i) * weight_ms * (64'd1 << FRAC_SHIFT);
            tab[i].quo = 33'(prod / MS_DAY_DEN);
            tab[i].rem = 17'(prod % MS_DAY_DEN);
        end
        return tab;
    endfunction

    // days from march 1 to the first of each month, month index 0 to 15
    function automatic doy_tab_t make_doy_tab();
        doy_tab_t tab;
        int       mp;
        for (int m = 0; m < 16; m++)
        begin
            mp = (m > 2) ? m - 3 : m + 9;
            tab[m] = 9'((153 * mp + 2) / 5);
        end
        return tab;
    endfunction

    localparam frac_tab_t HOUR_TAB   = make_frac_tab(64'd3600000);
    localparam frac_tab_t MINUTE_TAB = make_frac_tab(64'd60000);
    localparam frac_tab_t SECOND_TAB = make_frac_tab(64'd1000);
    localparam frac_tab_t MS_HI_TAB  = make_frac_tab(64'd32);
    localparam frac_tab_t MS_LO_TAB  = make_frac_tab(64'd1);
    localparam doy_tab_t  DOY_TAB    = make_doy_tab();

endpackage

// File: design/civil_date_to_spreadsheet_serial.sv
// civil_date_to_spreadsheet_serial: top level, input register, date and fraction logic, result register
// depends on cdss_pkg, cdss_date_days and cdss_day_frac
// path: an accepted item waits in the input register, then is converted and loaded into the result register
// throughput: 1 item per cycle while serial_stall is low, one pass through the date and fraction logic
// reset: clears only the two valid flags; payload registers keep whatever they hold
`timescale 1ns / 1ps

module civil_date_to_spreadsheet_serial import cdss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,

    // date and time items in
    input  logic      date_valid,
    output logic      date_stall,
    input  cdss_in_t  date,

    // serial date items out
    output logic      serial_valid,
    input  logic      serial_stall,
    output cdss_out_t serial
);

    // input register: holds one item while the result register is blocked
    logic      stage_valid_reg;
    logic      stage_valid_next;
    cdss_in_t  stage_reg;
    cdss_in_t  stage_next;

    // result register: drives the output channel directly
    logic      result_valid_reg;
    logic      result_valid_next;
    cdss_out_t result_reg;
    cdss_out_t result_next;

    logic       result_free;
    logic       load_result;
    logic       take_item;
    logic [24:0] date_days;
    cdss_frac_t  frac;

    // the result register can take a new item when it is empty or being drained
    assign result_free = !result_valid_reg || !serial_stall;
    assign load_result = stage_valid_reg && result_free;

    // stall only while the input register is full and cannot move on
    assign date_stall = stage_valid_reg && !result_free;
    assign take_item  = date_valid && !date_stall;

    // conversion logic between the two registers
    cdss_date_days u_date_days
    (
        .year_value  (stage_reg.year_value),
        .month_value (stage_reg.month_value),
        .day_value   (stage_reg.day_value),
        .days        (date_days)
    );

    cdss_day_frac u_day_frac
    (
        .hour_value   (stage_reg.hour_value),
        .minute_value (stage_reg.minute_value),
        .second_value (stage_reg.second_value),
        .milli_value  (stage_reg.milli_value),
        .frac         (frac)
    );

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_next       = stage_reg;
        if (take_item)
        begin
            stage_valid_next = 1'b1;
            stage_next       = date;
        end
        else if (load_result)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        if (result_free)
        begin
            result_valid_next = stage_valid_reg;
        end
        if (load_result)
        begin
            // a time of a full day or more carries one day into the serial
            result_next.serial_days  = signed'(date_days + 25'(frac.carry));
            result_next.day_fraction = frac.fraction;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg  <= stage_next;
        result_reg <= result_next;
    end

    assign serial_valid = result_valid_reg;
    assign serial       = result_reg;

    // an accepted item always lands in the input register
    a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
        take_item |=> stage_valid_reg)
        else $error("accepted item not held in input register");

    // a blocked item waits in place until the output drains
    a_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && result_valid_reg && serial_stall)
        |=> (stage_valid_reg && $stable(stage_reg)))
        else $error("blocked item lost or changed");

    // a held item moves to the result register once it is free
    a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
        load_result |=> result_valid_reg)
        else $error("result register failed to load");

    // only an hour value of 23 or more can overflow into the next day
    a_carry_hour: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && frac.carry) |-> (stage_reg.hour_value >= 5'd23))
        else $error("day carry with hour below 23");

endmodule

// File: design/cdss_date_days.sv
// cdss_date_days: whole days since 1899-12-30 from year, month and day, before time carry
// depends on cdss_pkg (bias constants, reciprocal for /25, day-of-year table)
`timescale 1ns / 1ps

module cdss_date_days import cdss_pkg::*;
(
    input  logic signed [15:0] year_value,
    input  logic [3:0]         month_value,
    input  logic [4:0]         day_value,
    output logic [24:0]        days
);

    logic        feb_or_less;
    logic [16:0] year_adj;
    logic [14:0] quarter;
    logic [12:0] sixteenth;
    logic [29:0] cent_prod;
    logic [27:0] quad_prod;
    logic [9:0]  cent;
    logic [7:0]  quad_cent;
    logic [24:0] year_days;
    logic [8:0]  doy;

    // january, february and month zero belong to the previous march-based year
    assign feb_or_less = (month_value <= 4'd2);
    assign year_adj    = 17'({year_value[15], year_value} + YEAR_BIAS - 17'(feb_or_less));

    // leap-day counts: floor(y/4), floor(y/100), floor(y/400)
    assign quarter   = year_adj[16:2];
    assign sixteenth = year_adj[16:4];
    assign cent_prod = 30'(quarter) * 30'(DIV25_MUL);
    assign quad_prod = 28'(sixteenth) * 28'(DIV25_MUL);
    assign cent      = 10'(cent_prod >> DIV25_SHIFT);
    assign quad_cent = 8'(quad_prod >> DIV25_SHIFT);

    assign year_days = 25'(year_adj) * DAYS_PER_YEAR;
    assign doy       = DOY_TAB[month_value];

    // modulo 2^25 sum, matches the masked result
    assign days = year_days + 25'(quarter) - 25'(cent) + 25'(quad_cent)
                + 25'(doy) + 25'(day_value) + SERIAL_BIAS;

endmodule

// File: design/cdss_day_frac.sv
// cdss_day_frac: time of day as 0.32 fraction of a day plus whole-day carry
// depends on cdss_pkg (per-field quotient/remainder tables, cdss_frac_t)
`timescale 1ns / 1ps

module cdss_day_frac import cdss_pkg::*;
(
    input  logic [4:0]  hour_value,
    input  logic [5:0]  minute_value,
    input  logic [5:0]  second_value,
    input  logic [9:0]  milli_value,
    output cdss_frac_t  frac
);

    frac_term_t  t_hour;
    frac_term_t  t_minute;
    frac_term_t  t_second;
    frac_term_t  t_ms_hi;
    frac_term_t  t_ms_lo;
    logic [32:0] quo_sum;
    logic [19:0] rem_sum;
    logic [2:0]  rem_carry;
    logic [32:0] total;

    assign t_hour   = HOUR_TAB[{1'b0, hour_value}];
    assign t_minute = MINUTE_TAB[minute_value];
    assign t_second = SECOND_TAB[second_value];
    assign t_ms_hi  = MS_HI_TAB[{1'b0, milli_value[9:5]}];
    assign t_ms_lo  = MS_LO_TAB[{1'b0, milli_value[4:0]}];

    assign quo_sum = t_hour.quo + t_minute.quo + t_second.quo + t_ms_hi.quo + t_ms_lo.quo;
    assign rem_sum = 20'(t_hour.rem) + 20'(t_minute.rem) + 20'(t_second.rem)
                   + 20'(t_ms_hi.rem) + 20'(t_ms_lo.rem);

    // remainders sum to under five divisors: count whole divisors in it
    assign rem_carry = 3'(rem_sum >= 20'(MS_DAY_DEN))
                     + 3'(rem_sum >= 20'(2 * MS_DAY_DEN))
                     + 3'(rem_sum >= 20'(3 * MS_DAY_DEN))
                     + 3'(rem_sum >= 20'(4 * MS_DAY_DEN));

    // bit 32 set means a full day or more
    assign total = quo_sum + 33'(rem_carry);

    assign frac.carry    = total[32];
    assign frac.fraction = total[31:0];

endmodule

// File: tb/civil_date_to_spreadsheet_serial_tb.sv
// civil_date_to_spreadsheet_serial_tb: self-checking bench for the date-to-serial block
// drives directed and random date items, predicts serial day and day fraction per item
// depends on cdss_pkg and civil_date_to_spreadsheet_serial
`timescale 1ns / 1ps

module civil_date_to_spreadsheet_serial_tb;
    import cdss_pkg::*;

    // calendar arithmetic constants (days-from-civil, march-based year)
    localparam longint          DAYS_IN_ERA   = 146097;
    localparam longint          CIVIL_TO_1970 = 719468;
    localparam longint          EPOCH_1970    = 25569;   // 1970-01-01 as a serial day
    localparam longint unsigned MS_IN_DAY     = 64'd86400000;

    localparam int RANDOM_ITEMS  = 1700;
    localparam int HOLD_CYCLES   = 60;     // long receiver hold-off
    localparam int STUCK_LIMIT   = 5000;   // cycles with no item moving either way
    localparam int DRAIN_CYCLES  = 10;     // extra cycles after the last result, as margin
    localparam int SHOWN_ERRORS  = 10;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      date_valid = 1'b0;
    logic      date_stall;
    cdss_in_t  date = '0;
    logic      serial_valid;
    logic      serial_stall = 1'b0;
    cdss_out_t serial;

    cdss_in_t    date_items[$];        // items waiting for the driver
    cdss_out_t   serial_expected[$];   // predicted results, oldest first
    int unsigned total_items;
    int unsigned items_taken = 0;
    int unsigned mismatches = 0;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_count;
    logic        hold_done;
    int unsigned stuck_cycles = 0;

    civil_date_to_spreadsheet_serial u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .date_valid   (date_valid),
        .date_stall   (date_stall),
        .date         (date),
        .serial_valid (serial_valid),
        .serial_stall (serial_stall),
        .serial       (serial)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // serial day and 0.32 day fraction for one date item
    function automatic cdss_out_t serial_from_civil(cdss_in_t d);
        longint          yr;
        longint          era;
        longint          yoe;
        longint          mp;
        longint          doy;
        longint          doe;
        longint          days;
        longint unsigned ms_total;
        longint unsigned whole_days;
        longint unsigned ms_left;
        longint unsigned frac;
        cdss_out_t       r;
        // jan and feb (and month zero) belong to the previous march-based year
        yr  = longint'($signed(d.year_value)) - ((d.month_value <= 4'd2) ? 1 : 0);
        // floor division by 400, also for negative years
        era = ((yr >= 0) ? yr : yr - 399) / 400;
        yoe = yr - era * 400;
        mp  = (d.month_value > 4'd2) ? longint'(d.month_value) - 3
                                     : longint'(d.month_value) + 9;
        // day count is linear in the day, so day zero and overlong days just run on
        doy = (153 * mp + 2) / 5 + longint'(d.day_value) - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        // out-of-range time fields only add milliseconds; at most one day carries
        ms_total = 64'(d.hour_value) * 64'd3600000 + 64'(d.minute_value) * 64'd60000
                 + 64'(d.second_value) * 64'd1000 + 64'(d.milli_value);
        whole_days = ms_total / MS_IN_DAY;
        ms_left    = ms_total % MS_IN_DAY;
        frac       = (ms_left << 32) / MS_IN_DAY;
        days = era * DAYS_IN_ERA + doe - CIVIL_TO_1970 + EPOCH_1970 + longint'(whole_days);
        r.serial_days  = days[24:0];
        r.day_fraction = frac[31:0];
        return r;
    endfunction

    function automatic cdss_in_t make_date(int y, int mo, int d, int h, int mi, int s, int ms);
        cdss_in_t t;
        t.year_value   = 16'(y);
        t.month_value  = 4'(mo);
        t.day_value    = 5'(d);
        t.hour_value   = 5'(h);
        t.minute_value = 6'(mi);
        t.second_value = 6'(s);
        t.milli_value  = 10'(ms);
        return t;
    endfunction

    // append one item at the tail of the pending queue
    function automatic void queue_date(cdss_in_t t);
        date_items.insert(date_items.size(), t);
    endfunction

    // well-formed dates most of the time, raw bit patterns otherwise
    function automatic cdss_in_t random_date(bit well_formed);
        cdss_in_t t;
        if (well_formed)
        begin
            if ($urandom_range(1) == 0)
                t.year_value = 16'($urandom_range(2300, 1800));
            else
                t.year_value = 16'($urandom);
            t.month_value  = 4'($urandom_range(12, 1));
            t.day_value    = 5'($urandom_range(31, 1));
            t.hour_value   = 5'($urandom_range(23, 0));
            t.minute_value = 6'($urandom_range(59, 0));
            t.second_value = 6'($urandom_range(59, 0));
            t.milli_value  = 10'($urandom_range(999, 0));
        end
        else
        begin
            t = cdss_in_t'($urandom ^ ({$urandom, $urandom} << 20));
        end
        return t;
    endfunction

    // idling schedule: sender-light, then receiver-light, then none
    always_comb
    begin
        if (items_taken < total_items / 3)
        begin
            send_idle_pct = 34;
            recv_idle_pct = 57;
        end
        else if (items_taken < (2 * total_items) / 3)
        begin
            send_idle_pct = 57;
            recv_idle_pct = 34;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // driver: predicts on acceptance, loads the next item once the current one is gone
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            date_valid <= 1'b0;
            date       <= '0;
        end
        else
        begin
            if (date_valid && !date_stall)
            begin
                serial_expected.insert(serial_expected.size(), serial_from_civil(date));
                items_taken <= items_taken + 1;
            end
            // payload only moves when nothing is pending or the pending item was taken
            if (!date_valid || !date_stall)
            begin
                if (date_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    date       <= date_items.pop_front();
                    date_valid <= 1'b1;
                end
                else
                begin
                    date_valid <= 1'b0;
                end
            end
        end
    end

    // one long hold-off in the no-idle phase so the pipe backs up into the input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count <= 0;
            hold_done  <= 1'b0;
        end
        else if (hold_count != 0)
        begin
            hold_count <= hold_count - 1;
        end
        else if (!hold_done && items_taken >= (5 * total_items) / 6)
        begin
            hold_count <= HOLD_CYCLES;
            hold_done  <= 1'b1;
        end
    end

    // monitor: compares each taken result with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        cdss_out_t want;
        if (!rst_n)
        begin
            serial_stall <= 1'b0;
        end
        else
        begin
            if (serial_valid && !serial_stall)
            begin
                if (serial_expected.size() == 0)
                begin
                    if (mismatches < SHOWN_ERRORS)
                        $display("unexpected result: serial_days %0d day_fraction %h",
                                 $signed(serial.serial_days), serial.day_fraction);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = serial_expected.pop_front();
                    if (serial.serial_days !== want.serial_days
                        || serial.day_fraction !== want.day_fraction)
                    begin
                        if (mismatches < SHOWN_ERRORS)
                            $display("mismatch: serial_days exp %0d got %0d, %s %h got %h",
                                     $signed(want.serial_days), $signed(serial.serial_days),
                                     "day_fraction exp", want.day_fraction,
                                     serial.day_fraction);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            serial_stall <= (hold_count != 0) || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog on cycles where no item moves on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((date_valid && !date_stall) || (serial_valid && !serial_stall))
                stuck_cycles <= 0;
            else if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("civil_date_to_spreadsheet_serial verification failed");
                $finish;
            end
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        // extremes of the year field
        queue_date(make_date(-32768, 1, 1, 0, 0, 0, 0));
        queue_date(make_date(32767, 12, 31, 23, 59, 59, 999));
        // epoch, the day before it, and the 1970 epoch
        queue_date(make_date(1899, 12, 30, 0, 0, 0, 0));
        queue_date(make_date(1899, 12, 29, 12, 0, 0, 0));
        queue_date(make_date(1970, 1, 1, 6, 30, 15, 500));
        // leap years and century rules
        queue_date(make_date(2000, 2, 29, 0, 0, 0, 1));
        queue_date(make_date(1900, 3, 1, 0, 0, 0, 0));
        queue_date(make_date(0, 2, 29, 0, 0, 0, 0));
        // negative eras around the floor division
        queue_date(make_date(-1, 3, 1, 0, 0, 0, 0));
        queue_date(make_date(-400, 1, 1, 0, 0, 0, 0));
        queue_date(make_date(-401, 12, 31, 23, 59, 59, 999));
        // month zero and months past december
        queue_date(make_date(2024, 0, 15, 0, 0, 0, 0));
        queue_date(make_date(2024, 13, 1, 0, 0, 0, 0));
        queue_date(make_date(2024, 14, 10, 0, 0, 0, 0));
        queue_date(make_date(-32768, 15, 31, 0, 0, 0, 0));
        // day zero and days past the month end
        queue_date(make_date(2023, 3, 0, 0, 0, 0, 0));
        queue_date(make_date(2023, 2, 31, 0, 0, 0, 0));
        // time totals of a full day or more carry into the day count; the last has only an overlong millisecond field
        queue_date(make_date(2023, 6, 1, 24, 0, 0, 0));
        queue_date(make_date(32767, 15, 31, 31, 63, 63, 1023));
        queue_date(make_date(-32768, 0, 0, 23, 59, 59, 1023));
        queue_date(make_date(1999, 12, 31, 0, 0, 0, 1023));

        for (int i = 0; i < RANDOM_ITEMS; i++)
            queue_date(random_date($urandom_range(99) < 80));
        total_items = date_items.size();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (items_taken < total_items || serial_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("civil_date_to_spreadsheet_serial verification clean");
        else
            $display("civil_date_to_spreadsheet_serial verification failed");
        $finish;
    end

endmodule

// File: sim.f
design/cdss_pkg.sv
design/cdss_date_days.sv
design/cdss_day_frac.sv
design/civil_date_to_spreadsheet_serial.sv
tb/civil_date_to_spreadsheet_serial_tb.sv
